// File: hdl/ppu_pkg.sv
// Shared types and constants for the predator-prey pair update block.
`timescale 1ns / 1ps
`default_nettype none
package ppu_pkg;

   // Fraction format: unsigned over 2^FRAC_W
   localparam int FRAC_W   = 16;
   localparam int PROB_W   = FRAC_W + 1;
   localparam int LEN_W    = 11;
   localparam int INDEX_W  = 10;
   localparam int FUNC_W   = 2;
   localparam int FRAC_ONE = 1 << FRAC_W;

   // u_choice below these falls in the first / first two thirds
   localparam logic [FRAC_W-1:0] THIRD_LIM_1 = FRAC_W'((FRAC_ONE + 2) / 3);
   localparam logic [FRAC_W-1:0] THIRD_LIM_2 = FRAC_W'((2 * FRAC_ONE + 2) / 3);

   // Item functions (the unused code acts as a read)
   localparam logic [FUNC_W-1:0] FUNC_UPDATE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE  = 2'd2;

   // Register indexes on the APB port
   localparam logic [1:0] REG_RING_LENGTH    = 2'd0;
   localparam logic [1:0] REG_GROWTH_PROB    = 2'd1;
   localparam logic [1:0] REG_DEATH_PROB     = 2'd2;
   localparam logic [1:0] REG_PREDATION_PROB = 2'd3;

   // Register reset values
   localparam logic [LEN_W-1:0]  RING_LENGTH_RST    = 11'd1000;
   localparam logic [PROB_W-1:0] GROWTH_PROB_RST    = 17'd20840;
   localparam logic [PROB_W-1:0] DEATH_PROB_RST     = 17'd13107;
   localparam logic [PROB_W-1:0] PREDATION_PROB_RST = 17'd65536;

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_MODIFY,
      S_WRITE_J,
      S_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic rd_en;
      logic calc;
      logic wr_left;
      logic wr_right;
      logic publish;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic in_range;
      logic is_update;
      logic is_write;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

// File: hdl/ppu_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ppu_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 1024
) (
   input  wire                      clock,
   input  wire                      we,
   input  wire [$clog2(DEPTH)-1:0]  waddr,
   input  wire [WIDTH-1:0]          wdata,
   input  wire                      re,
   input  wire [$clog2(DEPTH)-1:0]  raddr_a,
   input  wire [$clog2(DEPTH)-1:0]  raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read ports
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_a_ff <= mem_ff[raddr_a];
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule
`default_nettype wire

// File: hdl/ppu_dp.sv
// Datapath: item capture, cell memory, transition logic and result register.
`timescale 1ns / 1ps
`default_nettype none
module ppu_dp #(
   parameter int LATTICE_CELLS = 1024
) (
   input  wire                             clock,
   input  wire                             reset,
   input  ppu_pkg::cmd_type                cmd,
   output ppu_pkg::sts_type                sts,
   input  wire [ppu_pkg::FUNC_W-1:0]       req_func,
   input  wire [ppu_pkg::INDEX_W-1:0]      req_cell_index,
   input  wire [ppu_pkg::FRAC_W-1:0]       req_u_choice,
   input  wire [ppu_pkg::FRAC_W-1:0]       req_u_accept,
   input  wire                             req_write_prey,
   input  wire                             req_write_predator,
   input  wire [ppu_pkg::LEN_W-1:0]        ring_length,
   input  wire [ppu_pkg::PROB_W-1:0]       growth_prob,
   input  wire [ppu_pkg::PROB_W-1:0]       death_prob,
   input  wire [ppu_pkg::PROB_W-1:0]       predation_prob,
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic                            rsp_status,
   output logic                            rsp_prey_left,
   output logic                            rsp_predator_left,
   output logic                            rsp_prey_right,
   output logic                            rsp_predator_right,
   output logic                            rsp_changed
);
   import ppu_pkg::*;

   localparam int ADDR_W = $clog2(LATTICE_CELLS);

   // Pair code {prey_i, prey_j, pred_i, pred_j} after one stochastic step
   function automatic logic [3:0] next_pair(
      input logic [3:0] k,
      input logic       lo,
      input logic       th0,
      input logic       th1,
      input logic       acc_al,
      input logic       acc_be,
      input logic       acc_ga
   );
      logic [3:0] n;
      begin
         n = k;
         case (k) inside
            4'd1:  n = 4'd2;
            4'd2:  n = 4'd1;
            4'd3:  n = acc_be ? 4'd0 : k;
            4'd4:  n = lo ? (acc_al ? 4'd12 : k) : 4'd8;
            4'd5:  n = lo ? (acc_al ? 4'd14 : k) : 4'd10;
            4'd6:  n = th0 ? (acc_ga ? 4'd3 : k) : (th1 ? (acc_al ? 4'd13 : k) : 4'd9);
            4'd7, 4'd13:
                   n = th0 ? (acc_be ? 4'd8 : k) : (th1 ? (acc_al ? 4'd15 : k) : 4'd11);
            4'd8:  n = lo ? (acc_al ? 4'd12 : k) : 4'd4;
            4'd9:  n = th0 ? (acc_al ? 4'd14 : k) : (th1 ? (acc_ga ? 4'd3 : k) : 4'd6);
            4'd10: n = lo ? (acc_al ? 4'd13 : k) : 4'd5;
            4'd11: n = lo ? (acc_al ? 4'd15 : k) : (acc_be ? 4'd4 : k);
            4'd14: n = lo ? (acc_ga ? 4'd11 : k) : 4'd13;
            4'd15: n = acc_be ? 4'd12 : k;
            default: n = k;
         endcase
         return n;
      end
   endfunction

   // Item registers
   logic [FUNC_W-1:0]  func_ff;
   logic [INDEX_W-1:0] idx_ff;
   logic [ADDR_W-1:0]  j_ff;
   logic               same_ff;
   logic               in_range_ff;
   logic [FRAC_W-1:0]  uc_ff;
   logic [FRAC_W-1:0]  ua_ff;
   logic               wprey_ff;
   logic               wpred_ff;
   logic [3:0]         n_ff;
   logic [4:0]         res_ff;
   logic               rsp_valid_ff;
   logic               rsp_status_ff;
   logic [4:0]         rsp_bits_ff;

   logic [LEN_W-1:0]   len_eff;
   logic [LEN_W-1:0]   i_wide;
   logic [LEN_W-1:0]   i_p1;
   logic [LEN_W-1:0]   j_wide;
   logic [1:0]         rd_a;
   logic [1:0]         rd_b;
   logic [3:0]         k;
   logic [3:0]         n_in;
   logic [1:0]         left_in;
   logic [1:0]         right_in;
   logic [3:0]         after;
   logic [4:0]         res_in;
   logic               is_update;
   logic               is_write;
   logic               acc_al;
   logic               acc_be;
   logic               acc_ga;
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_waddr;
   logic [1:0]         ram_wdata;

   // Saturate ring length to the memory depth; derive neighbor
   always_comb begin
      len_eff = ({21'd0, ring_length} > 32'(LATTICE_CELLS)) ? LEN_W'(LATTICE_CELLS)
                                                             : ring_length;
      i_wide  = {1'b0, req_cell_index};
      i_p1    = i_wide + 11'd1;
      j_wide  = (i_p1 < len_eff) ? i_p1 : '0;
   end

   // Capture the item on accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff     <= req_func;
         idx_ff      <= req_cell_index;
         j_ff        <= ADDR_W'(j_wide);
         same_ff     <= (j_wide == i_wide);
         in_range_ff <= (i_wide < len_eff);
         uc_ff       <= req_u_choice;
         ua_ff       <= req_u_accept;
         wprey_ff    <= req_write_prey;
         wpred_ff    <= req_write_predator;
      end
   end

   assign is_update = (func_ff == FUNC_UPDATE);
   assign is_write  = (func_ff == FUNC_WRITE);

   // Cell memory, {prey, predator} per entry
   ppu_ram #(
      .WIDTH(2),
      .DEPTH(LATTICE_CELLS)
   ) u_cells (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .re      (cmd.rd_en),
      .raddr_a (ADDR_W'(idx_ff)),
      .raddr_b (j_ff),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   // Transition of the pair read this item
   always_comb begin
      acc_al = ({1'b0, ua_ff} < growth_prob);
      acc_be = ({1'b0, ua_ff} < death_prob);
      acc_ga = ({1'b0, ua_ff} < predation_prob);
      k      = {rd_a[1], rd_b[1], rd_a[0], rd_b[0]};
      n_in   = next_pair(k, ~uc_ff[FRAC_W-1], (uc_ff < THIRD_LIM_1),
                         (uc_ff < THIRD_LIM_2), acc_al, acc_be, acc_ga);
   end

   // Cell values as stored after the item; with a one-cell ring the right write wins
   always_comb begin
      if (is_update) begin
         right_in = {n_in[2], n_in[0]};
         left_in  = same_ff ? right_in : {n_in[3], n_in[1]};
      end else if (is_write) begin
         left_in  = {wprey_ff, wpred_ff};
         right_in = same_ff ? left_in : rd_b;
      end else begin
         left_in  = rd_a;
         right_in = rd_b;
      end
      after  = {left_in[1], right_in[1], left_in[0], right_in[0]};
      res_in = {left_in[1], left_in[0], right_in[1], right_in[0],
                is_update && (after != k)};
   end

   // Memory write: left cell first, right cell in the next cycle
   always_comb begin
      ram_we    = cmd.wr_left || cmd.wr_right;
      ram_waddr = cmd.wr_right ? j_ff : ADDR_W'(idx_ff);
      if (cmd.wr_right) begin
         ram_wdata = {n_ff[2], n_ff[0]};
      end else if (is_update) begin
         ram_wdata = {n_in[3], n_in[1]};
      end else begin
         ram_wdata = {wprey_ff, wpred_ff};
      end
   end

   // Hold the new pair and the result until published
   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         n_ff   <= n_in;
         res_ff <= res_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_status_ff <= ~in_range_ff;
         rsp_bits_ff   <= in_range_ff ? res_ff : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_prey_left      = rsp_bits_ff[4];
   assign rsp_predator_left  = rsp_bits_ff[3];
   assign rsp_prey_right     = rsp_bits_ff[2];
   assign rsp_predator_right = rsp_bits_ff[1];
   assign rsp_changed        = rsp_bits_ff[0];

   always_comb begin
      sts.in_range  = in_range_ff;
      sts.is_update = is_update;
      sts.is_write  = is_write;
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // A new beat only appears after a publish
   a_rise_needs_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.publish))
      else $error("result beat raised without publish");

   // Out-of-range items never touch the memory
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_left || cmd.wr_right) |-> in_range_ff)
      else $error("memory write for out-of-range item");

   // An error beat carries all-zero fields
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_bits_ff == 5'd0))
      else $error("error beat with nonzero fields");

endmodule
`default_nettype wire

// File: hdl/ppu_ctrl.sv
// Controller: sequences capture, read, modify, write-back and result publish.
`timescale 1ns / 1ps
`default_nettype none
module ppu_ctrl (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   output ppu_pkg::cmd_type  cmd,
   input  ppu_pkg::sts_type  sts
);
   import ppu_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_READ;
         end
         S_READ: begin
            state_in = sts.in_range ? S_MODIFY : S_FINISH;
         end
         S_MODIFY: begin
            state_in = sts.is_update ? S_WRITE_J : S_FINISH;
         end
         S_WRITE_J: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         S_READ: begin
            cmd.rd_en = sts.in_range;
         end
         S_MODIFY: begin
            cmd.calc    = 1'b1;
            cmd.wr_left = sts.is_update || sts.is_write;
         end
         S_WRITE_J: begin
            cmd.wr_right = 1'b1;
         end
         S_FINISH: begin
            cmd.publish = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // Right-cell write always follows the left-cell write
   a_right_after_left: assert property (@(posedge clock) disable iff (reset)
      cmd.wr_right |-> $past(cmd.wr_left))
      else $error("right write without preceding left write");

   // A memory read is consumed in the next cycle
   a_read_then_calc: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |=> cmd.calc)
      else $error("read data not consumed");

   // Accepting a beat closes the input until the item is done
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second beat accepted while busy");

endmodule
`default_nettype wire

// File: hdl/predator_prey_pair_update.sv
// Top level: APB register file, controller and datapath of the pair update block.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_stall  func, cell_index, u_choice, u_accept,
//                                               write_prey, write_predator
//   rsp       out        rsp_valid / rsp_stall  status, prey/predator left/right, changed
//   csr       in/out     APB psel/penable       4 registers at byte address 4*i
//
// An update goes through the read, modify, right-write and finish states after accept;
// a read or write skips right-write, and an out-of-range index skips modify as well. The
// one memory write port writes the left and right cells in separate cycles after a
// registered read of both.
// Reset is synchronous, clears control state and loads the register reset values;
// cell contents are not cleared and hold nothing defined until written.
// A result beat waits in the output register under rsp_stall while the next
// item is taken; the item after that waits until the beat has left.
`timescale 1ns / 1ps
`default_nettype none
module predator_prey_pair_update #(
   parameter int LATTICE_CELLS = 1024
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire [ppu_pkg::FUNC_W-1:0]        req_func,
   input  wire [ppu_pkg::INDEX_W-1:0]       req_cell_index,
   input  wire [ppu_pkg::FRAC_W-1:0]        req_u_choice,
   input  wire [ppu_pkg::FRAC_W-1:0]        req_u_accept,
   input  wire                              req_write_prey,
   input  wire                              req_write_predator,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_status,
   output logic                             rsp_prey_left,
   output logic                             rsp_predator_left,
   output logic                             rsp_prey_right,
   output logic                             rsp_predator_right,
   output logic                             rsp_changed,
   input  wire                              psel,
   input  wire                              penable,
   input  wire                              pwrite,
   input  wire [3:0]                        paddr,
   input  wire [31:0]                       pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import ppu_pkg::*;

   logic [LEN_W-1:0]  ring_length_ff;
   logic [PROB_W-1:0] growth_prob_ff;
   logic [PROB_W-1:0] death_prob_ff;
   logic [PROB_W-1:0] predation_prob_ff;
   logic              csr_write;
   cmd_type           cmd;
   sts_type           sts;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_length_ff    <= RING_LENGTH_RST;
         growth_prob_ff    <= GROWTH_PROB_RST;
         death_prob_ff     <= DEATH_PROB_RST;
         predation_prob_ff <= PREDATION_PROB_RST;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_RING_LENGTH:    ring_length_ff    <= pwdata[LEN_W-1:0];
            REG_GROWTH_PROB:    growth_prob_ff    <= pwdata[PROB_W-1:0];
            REG_DEATH_PROB:     death_prob_ff     <= pwdata[PROB_W-1:0];
            REG_PREDATION_PROB: predation_prob_ff <= pwdata[PROB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Register reads
   always_comb begin
      unique case (paddr[3:2])
         REG_RING_LENGTH:    prdata = 32'(ring_length_ff);
         REG_GROWTH_PROB:    prdata = 32'(growth_prob_ff);
         REG_DEATH_PROB:     prdata = 32'(death_prob_ff);
         REG_PREDATION_PROB: prdata = 32'(predation_prob_ff);
         default:            prdata = '0;
      endcase
   end

   ppu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ppu_dp #(
      .LATTICE_CELLS(LATTICE_CELLS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_func           (req_func),
      .req_cell_index     (req_cell_index),
      .req_u_choice       (req_u_choice),
      .req_u_accept       (req_u_accept),
      .req_write_prey     (req_write_prey),
      .req_write_predator (req_write_predator),
      .ring_length        (ring_length_ff),
      .growth_prob        (growth_prob_ff),
      .death_prob         (death_prob_ff),
      .predation_prob     (predation_prob_ff),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_prey_left      (rsp_prey_left),
      .rsp_predator_left  (rsp_predator_left),
      .rsp_prey_right     (rsp_prey_right),
      .rsp_predator_right (rsp_predator_right),
      .rsp_changed        (rsp_changed)
   );

endmodule
`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the predator-prey pair update block.
`timescale 1ns / 1ps
module tb;
   import ppu_pkg::*;

   localparam int LATTICE_CELLS = 1024;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int DRAIN_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;
   // u_choice edges: last value of the first third, lower half, second third
   localparam int THIRD_EDGE_1 = (FRAC_ONE - 1) / 3;
   localparam int HALF_EDGE    = FRAC_ONE / 2 - 1;
   localparam int THIRD_EDGE_2 = (2 * FRAC_ONE - 1) / 3;
   localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] cell_index;
      logic [FRAC_W-1:0]  u_choice;
      logic [FRAC_W-1:0]  u_accept;
      logic               write_prey;
      logic               write_predator;
   } lattice_op_type;

   typedef struct packed {
      logic status;
      logic prey_left;
      logic predator_left;
      logic prey_right;
      logic predator_right;
      logic changed;
   } pair_view_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [FUNC_W-1:0]  req_func = FUNC_READ;
   logic [INDEX_W-1:0] req_cell_index = '0;
   logic [FRAC_W-1:0]  req_u_choice = '0;
   logic [FRAC_W-1:0]  req_u_accept = '0;
   logic req_write_prey = 1'b0;
   logic req_write_predator = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_status, rsp_prey_left, rsp_predator_left;
   logic rsp_prey_right, rsp_predator_right, rsp_changed;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   predator_prey_pair_update #(.LATTICE_CELLS(LATTICE_CELLS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req_func), .req_cell_index(req_cell_index),
      .req_u_choice(req_u_choice), .req_u_accept(req_u_accept),
      .req_write_prey(req_write_prey), .req_write_predator(req_write_predator),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_prey_left(rsp_prey_left),
      .rsp_predator_left(rsp_predator_left), .rsp_prey_right(rsp_prey_right),
      .rsp_predator_right(rsp_predator_right), .rsp_changed(rsp_changed),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Shadow of the lattice and the registers
   bit lattice_prey [LATTICE_CELLS];
   bit lattice_predator [LATTICE_CELLS];
   logic [LEN_W-1:0]  cfg_ring_length = RING_LENGTH_RST;
   logic [PROB_W-1:0] cfg_growth      = GROWTH_PROB_RST;
   logic [PROB_W-1:0] cfg_death       = DEATH_PROB_RST;
   logic [PROB_W-1:0] cfg_predation   = PREDATION_PROB_RST;

   pair_view_type expected_pairs[$];
   int mismatch_count = 0;
   int cycle_count = 0;
   int burst_left = 0;
   int last_index = 0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int stall_mode = 0;
   int mode_left = 0;

   always #5 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [3:0] take_branch(logic [FRAC_W-1:0] ua, logic [PROB_W-1:0] prob,
                                               logic [3:0] target, logic [3:0] code);
      return ({1'b0, ua} < prob) ? target : code;
   endfunction

   // Stochastic transition of one pair code
   function automatic logic [3:0] next_pair_code(logic [3:0] code, logic [FRAC_W-1:0] uc,
                                                  logic [FRAC_W-1:0] ua);
      logic lower;
      int triple;
      int third;
      lower = int'(uc) <= HALF_EDGE;
      triple = 3 * int'(uc);
      if (triple < FRAC_ONE) third = 0;
      else if (triple < 2 * FRAC_ONE) third = 1;
      else third = 2;
      case (code)
         4'd1: return 4'd2;
         4'd2: return 4'd1;
         4'd3: return take_branch(ua, cfg_death, 4'd0, code);
         4'd4: return lower ? take_branch(ua, cfg_growth, 4'd12, code) : 4'd8;
         4'd5: return lower ? take_branch(ua, cfg_growth, 4'd14, code) : 4'd10;
         4'd6: begin
            if (third == 0) return take_branch(ua, cfg_predation, 4'd3, code);
            if (third == 1) return take_branch(ua, cfg_growth, 4'd13, code);
            return 4'd9;
         end
         4'd7, 4'd13: begin
            if (third == 0) return take_branch(ua, cfg_death, 4'd8, code);
            if (third == 1) return take_branch(ua, cfg_growth, 4'd15, code);
            return 4'd11;
         end
         4'd8: return lower ? take_branch(ua, cfg_growth, 4'd12, code) : 4'd4;
         4'd9: begin
            if (third == 0) return take_branch(ua, cfg_growth, 4'd14, code);
            if (third == 1) return take_branch(ua, cfg_predation, 4'd3, code);
            return 4'd6;
         end
         4'd10: return lower ? take_branch(ua, cfg_growth, 4'd13, code) : 4'd5;
         4'd11: return lower ? take_branch(ua, cfg_growth, 4'd15, code)
                             : take_branch(ua, cfg_death, 4'd4, code);
         4'd14: return lower ? take_branch(ua, cfg_predation, 4'd11, code) : 4'd13;
         4'd15: return take_branch(ua, cfg_death, 4'd12, code);
         default: return code;
      endcase
   endfunction

   function automatic int ring_span();
      return (cfg_ring_length > LATTICE_CELLS) ? LATTICE_CELLS : int'(cfg_ring_length);
   endfunction

   // Apply one accepted op to the shadow lattice and return the pair it reports
   function automatic pair_view_type update_lattice(lattice_op_type op);
      pair_view_type view;
      int span;
      int left;
      int right;
      logic [3:0] prior;
      logic [3:0] landed;
      view = '0;
      span = ring_span();
      left = op.cell_index;
      if (left >= span) begin
         view.status = STATUS_RANGE;
         return view;
      end
      right = (left + 1 < span) ? left + 1 : 0;
      if (op.func == FUNC_UPDATE) begin
         prior = {lattice_prey[left], lattice_prey[right],
                  lattice_predator[left], lattice_predator[right]};
         landed = next_pair_code(prior, op.u_choice, op.u_accept);
         // left first, right second: the right cell wins on a ring of one
         lattice_prey[left] = landed[3];
         lattice_predator[left] = landed[1];
         lattice_prey[right] = landed[2];
         lattice_predator[right] = landed[0];
         view.changed = ({lattice_prey[left], lattice_prey[right],
                          lattice_predator[left], lattice_predator[right]} != prior);
      end else if (op.func == FUNC_WRITE) begin
         lattice_prey[left] = op.write_prey;
         lattice_predator[left] = op.write_predator;
      end
      view.status = STATUS_OK;
      view.prey_left = lattice_prey[left];
      view.predator_left = lattice_predator[left];
      view.prey_right = lattice_prey[right];
      view.predator_right = lattice_predator[right];
      return view;
   endfunction

   task automatic compare_bit(string field, logic want, logic got);
      if (got !== want) begin
         $error("%s mismatch: expected %0b, actual %0b", field, want, got);
         mismatch_count++;
      end
   endtask

   // Receiver: check each beat, stall on a shifting pattern or a long hold-off
   always @(posedge clock) begin
      pair_view_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pairs.size() == 0) begin
               $error("result beat with no expectation pending");
               mismatch_count++;
            end else begin
               want = expected_pairs.pop_front();
               compare_bit("status", want.status, rsp_status);
               compare_bit("prey_left", want.prey_left, rsp_prey_left);
               compare_bit("predator_left", want.predator_left, rsp_predator_left);
               compare_bit("prey_right", want.prey_right, rsp_prey_right);
               compare_bit("predator_right", want.predator_right, rsp_predator_right);
               compare_bit("changed", want.changed, rsp_changed);
            end
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ~rsp_stall;
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Offer one beat, with random gaps between bursts, and predict it on accept
   task automatic send_op(lattice_op_type op);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= op.func;
      req_cell_index <= op.cell_index;
      req_u_choice <= op.u_choice;
      req_u_accept <= op.u_accept;
      req_write_prey <= op.write_prey;
      req_write_predator <= op.write_predator;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_pairs.push_back(update_lattice(op));
   endtask

   task automatic send_fields(logic [FUNC_W-1:0] func, int index, int uc, int ua,
                              logic prey, logic predator);
      lattice_op_type op;
      op.func = func;
      op.cell_index = INDEX_W'(index);
      op.u_choice = FRAC_W'(uc);
      op.u_accept = FRAC_W'(ua);
      op.write_prey = prey;
      op.write_predator = predator;
      send_op(op);
   endtask

   // Drop valid and wait until every expected beat has come back
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (expected_pairs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] index, int unsigned value);
      drain();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         REG_RING_LENGTH:    cfg_ring_length = LEN_W'(value);
         REG_GROWTH_PROB:    cfg_growth = PROB_W'(value);
         REG_DEATH_PROB:     cfg_death = PROB_W'(value);
         default:            cfg_predation = PROB_W'(value);
      endcase
      @(posedge clock);
   endtask

   task automatic check_register(logic [1:0] index, int unsigned want);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {index, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want) begin
         $error("register %0d mismatch: expected %0d, actual %0d", index, want, prdata);
         mismatch_count++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_probs(int unsigned growth, int unsigned death, int unsigned predation);
      write_register(REG_GROWTH_PROB, growth);
      write_register(REG_DEATH_PROB, death);
      write_register(REG_PREDATION_PROB, predation);
   endtask

   function automatic int unsigned pick_prob();
      case ($urandom_range(0, 5))
         0: return 0;
         1: return FRAC_ONE;
         2: return (1 << PROB_W) - 1;
         default: return $urandom_range(0, FRAC_ONE);
      endcase
   endfunction

   // u_choice inside one of the four half/third zones, edges favored
   function automatic int pick_choice(int zone);
      int lo_val;
      int hi_val;
      case (zone)
         0: begin lo_val = 0; hi_val = THIRD_EDGE_1; end
         1: begin lo_val = THIRD_EDGE_1 + 1; hi_val = HALF_EDGE; end
         2: begin lo_val = HALF_EDGE + 1; hi_val = THIRD_EDGE_2; end
         default: begin lo_val = THIRD_EDGE_2 + 1; hi_val = FRAC_ONE - 1; end
      endcase
      case ($urandom_range(0, 3))
         0: return lo_val;
         1: return hi_val;
         default: return $urandom_range(lo_val, hi_val);
      endcase
   endfunction

   // u_accept around one of the live probabilities
   function automatic int pick_accept();
      int prob;
      case ($urandom_range(0, 2))
         0: prob = cfg_growth;
         1: prob = cfg_death;
         default: prob = cfg_predation;
      endcase
      if (prob > FRAC_ONE - 1) prob = FRAC_ONE - 1;
      case ($urandom_range(0, 4))
         0: return 0;
         1: return FRAC_ONE - 1;
         2: return (prob == 0) ? 0 : prob - 1;
         3: return prob;
         default: return $urandom_range(0, FRAC_ONE - 1);
      endcase
   endfunction

   // Reset values of the registers, and range errors under the reset length
   task automatic test_reset_state();
      check_register(REG_RING_LENGTH, RING_LENGTH_RST);
      check_register(REG_GROWTH_PROB, GROWTH_PROB_RST);
      check_register(REG_DEATH_PROB, DEATH_PROB_RST);
      check_register(REG_PREDATION_PROB, PREDATION_PROB_RST);
      send_fields(FUNC_UPDATE, 1000, 0, 0, 1'b0, 1'b0);
      send_fields(FUNC_READ, LATTICE_CELLS - 1, 0, 0, 1'b0, 1'b0);
   endtask

   // Give every cell a defined value before anything reads it: cell 0 first on a
   // ring of one, then downward so each write reports an already written neighbor
   task automatic test_fill_lattice();
      write_register(REG_RING_LENGTH, 1);
      send_fields(FUNC_WRITE, 0, $urandom, $urandom, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      write_register(REG_RING_LENGTH, LATTICE_CELLS);
      for (int n = LATTICE_CELLS - 1; n > 0; n--)
         send_fields(FUNC_WRITE, n, $urandom, $urandom, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
   endtask

   // Extremes: wrap at the ring end, spare func, ring of one, empty and oversized rings
   task automatic test_directed();
      send_fields(FUNC_READ, 0, 0, 0, 1'b0, 1'b0);
      send_fields(FUNC_READ, LATTICE_CELLS - 1, 0, 0, 1'b0, 1'b0);
      send_fields(FUNC_SPARE, 512, FRAC_ONE - 1, FRAC_ONE - 1, 1'b1, 1'b1);
      send_fields(FUNC_WRITE, LATTICE_CELLS - 1, 0, 0, 1'b1, 1'b1);
      send_fields(FUNC_WRITE, 0, FRAC_ONE - 1, FRAC_ONE - 1, 1'b0, 1'b0);
      send_fields(FUNC_UPDATE, LATTICE_CELLS - 1, 0, 0, 1'b0, 1'b0);
      send_fields(FUNC_UPDATE, LATTICE_CELLS - 1, FRAC_ONE - 1, FRAC_ONE - 1, 1'b1, 1'b1);
      set_probs(0, (1 << PROB_W) - 1, 0);
      send_fields(FUNC_UPDATE, LATTICE_CELLS - 1, 0, 0, 1'b0, 1'b0);
      send_fields(FUNC_UPDATE, LATTICE_CELLS - 1, FRAC_ONE - 1, FRAC_ONE - 1, 1'b0, 1'b0);
      write_register(REG_RING_LENGTH, 1);
      send_fields(FUNC_WRITE, 0, 0, 0, 1'b1, 1'b1);
      send_fields(FUNC_UPDATE, 0, 0, 0, 1'b0, 1'b0);
      send_fields(FUNC_READ, 0, 0, 0, 1'b0, 1'b0);
      send_fields(FUNC_UPDATE, 0, FRAC_ONE - 1, FRAC_ONE - 1, 1'b0, 1'b0);
      send_fields(FUNC_READ, 1, 0, 0, 1'b0, 1'b0);
      write_register(REG_RING_LENGTH, 0);
      send_fields(FUNC_READ, 0, 0, 0, 1'b0, 1'b0);
      send_fields(FUNC_WRITE, 0, 0, 0, 1'b1, 1'b0);
      write_register(REG_RING_LENGTH, (1 << LEN_W) - 1);
      send_fields(FUNC_READ, LATTICE_CELLS - 1, 0, 0, 1'b0, 1'b0);
      send_fields(FUNC_UPDATE, LATTICE_CELLS - 1, HALF_EDGE, 0, 1'b0, 1'b0);
      write_register(REG_RING_LENGTH, 2);
      send_fields(FUNC_UPDATE, 1, THIRD_EDGE_1, 0, 1'b0, 1'b0);
      send_fields(FUNC_READ, 1, 0, 0, 1'b0, 1'b0);
   endtask

   // Set up every pair code and push it through every choice zone
   task automatic test_transition_codes();
      int span;
      int left;
      int right;
      for (int round = 0; round < 2; round++) begin
         if (round == 0) begin
            write_register(REG_RING_LENGTH, $urandom_range(2, 64));
            set_probs($urandom_range(0, FRAC_ONE), $urandom_range(0, FRAC_ONE),
                      $urandom_range(0, FRAC_ONE));
         end else begin
            write_register(REG_RING_LENGTH, LATTICE_CELLS);
            set_probs(pick_prob(), pick_prob(), pick_prob());
         end
         span = ring_span();
         for (int code = 0; code < 16; code++) begin
            for (int zone = 0; zone < 4; zone++) begin
               left = ($urandom_range(0, 3) == 0) ? span - 1 : $urandom_range(0, span - 1);
               right = (left + 1 < span) ? left + 1 : 0;
               send_fields(FUNC_WRITE, left, $urandom, $urandom, code[3], code[1]);
               send_fields(FUNC_WRITE, right, $urandom, $urandom, code[2], code[0]);
               send_fields(FUNC_UPDATE, left, pick_choice(zone), pick_accept(),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
         end
      end
   endtask

   // Mixed traffic over several ring lengths, biased toward neighboring pairs
   task automatic test_random_mix();
      int span;
      int pick;
      int index;
      logic [FUNC_W-1:0] func;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_register(REG_RING_LENGTH, 2);
            1: write_register(REG_RING_LENGTH, 1);
            2: write_register(REG_RING_LENGTH, 0);
            3: write_register(REG_RING_LENGTH, (1 << LEN_W) - 1);
            4: write_register(REG_RING_LENGTH, LATTICE_CELLS);
            5: write_register(REG_RING_LENGTH, $urandom_range(2, LATTICE_CELLS));
            6: write_register(REG_RING_LENGTH, 3);
            default: write_register(REG_RING_LENGTH, $urandom_range(2, 32));
         endcase
         set_probs(pick_prob(), pick_prob(), pick_prob());
         span = ring_span();
         for (int n = 0; n < 20; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) func = FUNC_UPDATE;
            else if (pick < 70) func = FUNC_READ;
            else if (pick < 92) func = FUNC_WRITE;
            else func = FUNC_SPARE;
            pick = $urandom_range(0, 99);
            if (span == 0) index = $urandom_range(0, LATTICE_CELLS - 1);
            else if (pick < 10 && span < LATTICE_CELLS)
               index = $urandom_range(span, LATTICE_CELLS - 1);
            else if (pick < 45) index = (last_index + $urandom_range(0, 2) + span - 1) % span;
            else index = $urandom_range(0, span - 1);
            if (span != 0) last_index = index % span;
            send_fields(func, index, $urandom_range(0, 1) ? $urandom : pick_choice(pick % 4),
                        $urandom_range(0, 1) ? $urandom : pick_accept(),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   // Hold off the receiver while the sender keeps offering, to fill the block
   task automatic test_backpressure();
      write_register(REG_RING_LENGTH, 16);
      set_probs($urandom_range(0, FRAC_ONE), $urandom_range(0, FRAC_ONE),
                $urandom_range(0, FRAC_ONE));
      hold_request = 1'b1;
      burst_left = 60;
      for (int n = 0; n < 40; n++)
         send_fields(FUNC_UPDATE, $urandom_range(0, 15), $urandom, $urandom, 1'b0, 1'b0);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_fill_lattice();
      test_directed();
      test_transition_codes();
      test_random_mix();
      test_backpressure();
      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_pairs.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
